/* rtl/mm128_pkg.sv */
// Package for montgomery_mul_128: payload types, widths, register indexes.
// No dependencies.
`default_nettype none
package mm128_pkg;
  localparam int unsigned HalfW = 64;
  localparam int unsigned FullW = 128;
  localparam int unsigned LimbW = 32;
  localparam int unsigned NumLimb = FullW / LimbW;
  // three multiplications of NumLimb x NumLimb limb steps, then the reduce cell
  localparam int unsigned NumCells = 3 * NumLimb * NumLimb + 1;

  typedef enum logic [1:0] {
    REG_MODULUS_LOW  = 2'd0,
    REG_MODULUS_HIGH = 2'd1,
    REG_NEG_INV_LOW  = 2'd2,
    REG_NEG_INV_HIGH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [HalfW-1:0] a_low;
    logic [HalfW-1:0] a_high;
    logic [HalfW-1:0] b_low;
    logic [HalfW-1:0] b_high;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] product_low;
    logic [HalfW-1:0] product_high;
    logic             reduction_failed;
  } out_item_t;

  // work carried down the chain
  typedef struct packed {
    logic [FullW-1:0]   x;
    logic [FullW-1:0]   y;
    logic [2*FullW:0]   acc;
    logic [2*FullW-1:0] t;
    logic [FullW-1:0]   res;
    logic               fail;
  } work_t;

  typedef struct packed {
    logic [FullW-1:0] modulus;
    logic [FullW-1:0] neg_inv;
  } cfg_t;
endpackage
`default_nettype wire

/* rtl/montgomery_mul_128.sv */
// Montgomery multiplier, 128 bit, as a chain of 49 cells (one 32x32 limb
// product each, then a reduce cell) plus an output register.
// Each item passes the cell registers, then the output register; one item per cycle while not stalled.
// The whole chain advances whenever the output register is empty or being taken.
// Reset: synchronous, clears valids; modulus=1, inverse=all ones.
// Uses mm128_pkg and mm128_cell.
`default_nettype none
module montgomery_mul_128 (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mm128_pkg::in_item_t in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mm128_pkg::out_item_t     out_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  localparam int unsigned Cells = mm128_pkg::NumCells;

  mm128_pkg::cfg_t  cfg;
  mm128_pkg::work_t w_in;
  mm128_pkg::work_t w [Cells+1];
  logic             v [Cells+1];
  logic             adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus <= 128'd1;
      cfg.neg_inv <= '1;
    end else if (cfg_we) begin
      case (mm128_pkg::reg_index_t'(cfg_index))
        mm128_pkg::REG_MODULUS_LOW:  cfg.modulus[63:0] <= cfg_data;
        mm128_pkg::REG_MODULUS_HIGH: cfg.modulus[127:64] <= cfg_data;
        mm128_pkg::REG_NEG_INV_LOW:  cfg.neg_inv[63:0] <= cfg_data;
        mm128_pkg::REG_NEG_INV_HIGH: cfg.neg_inv[127:64] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    w_in = '0;
    w_in.x = {in_item.a_high, in_item.a_low};
    w_in.y = {in_item.b_high, in_item.b_low};
  end

  assign w[0] = w_in;
  assign v[0] = in_valid;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    mm128_cell #(.Step(i)) u_cell (
      .clk(clk), .rst(rst), .vin(v[i]), .win(w[i]), .cfg(cfg), .adv(adv),
      .vout(v[i+1]), .wout(w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[Cells];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.product_low <= w[Cells].res[63:0];
      out_item.product_high <= w[Cells].res[127:64];
      out_item.reduction_failed <= w[Cells].fail;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed under stall");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.reduction_failed |-> out_item.product_low == '0
    && out_item.product_high == '0)
    else $error("failed item carries data");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("stall with empty output");
endmodule
`default_nettype wire

/* rtl/mm128_cell.sv */
// One chain cell of montgomery_mul_128: a 32x32 limb product step of one
// of three multiplications, or the final reduce/compare. Uses mm128_pkg.
`default_nettype none
module mm128_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            vin,
  input  wire mm128_pkg::work_t win,
  input  wire mm128_pkg::cfg_t  cfg,
  input  wire logic            adv,
  output logic                 vout,
  output mm128_pkg::work_t     wout
);
  localparam int unsigned L = mm128_pkg::LimbW;
  localparam int unsigned N = mm128_pkg::NumLimb;
  localparam int unsigned W = mm128_pkg::FullW;
  localparam int unsigned PhaseLen = N * N;
  // Steps 0..15: t=a*b. 16..31: q=tl*ni. 32..47: q*m added onto t. 48: reduce.
  localparam int unsigned Phase = Step / PhaseLen;
  localparam int unsigned I = (Step % PhaseLen) / N;
  localparam int unsigned J = Step % N;
  localparam bit LastStep = (I == N-1) && (J == N-1);

  mm128_pkg::work_t w;
  logic [2*L-1:0] pp;
  logic [2*W:0]   sum;
  logic [W-1:0]   u;

  always_comb begin
    w = win;
    pp = '0;
    sum = '0;
    u = '0;
    case (Phase)
      0, 1, 2: begin
        pp = (2*L)'(win.x[I*L +: L]) * (2*L)'(win.y[J*L +: L]);
        sum = win.acc + ((2*W+1)'(pp) << ((I+J)*L));
        w.acc = sum;
        if (LastStep) begin
          if (Phase == 0) begin
            w.t = sum[2*W-1:0];
            w.x = sum[W-1:0];
            w.y = cfg.neg_inv;
            w.acc = '0;
          end else if (Phase == 1) begin
            // q times modulus accumulates straight onto t
            w.x = sum[W-1:0];
            w.y = cfg.modulus;
            w.acc = (2*W+1)'(win.t);
          end
        end
      end
      default: begin
        // acc holds s
        u = win.acc[2*W-1:W];
        if (win.acc[2*W] || (win.acc[W-1:0] != '0)) begin
          w.res = '0;
          w.fail = 1'b1;
        end else begin
          w.fail = 1'b0;
          if (u >= cfg.modulus) w.res = u - cfg.modulus;
          else w.res = u;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wout <= w;
    end
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for montgomery_mul_128: drives operand items under several idle and stall
// patterns and register settings, and checks every product against a local predictor.
// Depends on mm128_pkg and the montgomery_mul_128 RTL.
`default_nettype none
module tb_top;
  localparam int unsigned FullW = mm128_pkg::FullW;
  localparam int unsigned Latency = 50;
  localparam int unsigned StallLimit = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  mm128_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  mm128_pkg::out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;

  montgomery_mul_128 i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [FullW-1:0] cur_modulus;
  logic [FullW-1:0] cur_neg_inv;

  mm128_pkg::out_item_t pending_products[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned products_seen;
  int unsigned failures_seen;
  int unsigned idle_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic mm128_pkg::out_item_t montgomery_product(mm128_pkg::in_item_t it,
                                                              logic [FullW-1:0] m,
                                                              logic [FullW-1:0] ni);
    logic [2*FullW-1:0] t;
    logic [2*FullW-1:0] qw;
    logic [FullW-1:0] q;
    logic [2*FullW-1:0] qm;
    logic [2*FullW:0] s;
    logic [FullW-1:0] u;
    mm128_pkg::out_item_t r;
    t = {128'd0, it.a_high, it.a_low} * {128'd0, it.b_high, it.b_low};
    qw = {128'd0, t[FullW-1:0]} * {128'd0, ni};
    q = qw[FullW-1:0];
    qm = {128'd0, q} * {128'd0, m};
    s = {1'b0, t} + {1'b0, qm};
    if (s[2*FullW] || s[FullW-1:0] != '0) begin
      r = '{product_low: '0, product_high: '0, reduction_failed: 1'b1};
    end else begin
      u = s[2*FullW-1:FullW];
      if (u >= m) u = u - m;
      r = '{product_low: u[63:0], product_high: u[127:64], reduction_failed: 1'b0};
    end
    return r;
  endfunction

  function automatic logic [FullW-1:0] neg_inverse_of(logic [FullW-1:0] m);
    logic [FullW-1:0] x;
    x = m;
    for (int k = 0; k < 7; k++) x = x * (128'd2 - m * x);
    return -x;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FullW-1:0] rand128();
    return {rand64(), rand64()};
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    mm128_pkg::out_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      products_seen++;
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: product with none expected: %p", out_item);
      end else begin
        exp_item = pending_products.pop_front();
        if (exp_item.reduction_failed) failures_seen++;
        if (out_item.product_low !== exp_item.product_low
            || out_item.product_high !== exp_item.product_high
            || out_item.reduction_failed !== exp_item.reduction_failed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: product mismatch exp lo=%h hi=%h fail=%b got lo=%h hi=%h fail=%b",
                     exp_item.product_low, exp_item.product_high, exp_item.reduction_failed,
                     out_item.product_low, out_item.product_high,
                     out_item.reduction_failed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("ERROR: no progress for %0d cycles", StallLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(mm128_pkg::in_item_t it);
    @(negedge clk);
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    pending_products.insert(pending_products.size(),
                            montgomery_product(it, cur_modulus, cur_neg_inv));
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic send_operands(logic [FullW-1:0] a, logic [FullW-1:0] b);
    send_item('{a_low: a[63:0], a_high: a[127:64], b_low: b[63:0], b_high: b[127:64]});
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_products.size() == 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(mm128_pkg::reg_index_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_modulus(logic [FullW-1:0] m, logic [FullW-1:0] ni);
    wait_drain();
    write_reg(mm128_pkg::REG_MODULUS_LOW, m[63:0]);
    write_reg(mm128_pkg::REG_MODULUS_HIGH, m[127:64]);
    write_reg(mm128_pkg::REG_NEG_INV_LOW, ni[63:0]);
    write_reg(mm128_pkg::REG_NEG_INV_HIGH, ni[127:64]);
    cur_modulus = m;
    cur_neg_inv = ni;
  endtask

  // operands mostly reduced below the modulus, some unreduced noise
  task automatic send_random(int unsigned count);
    logic [FullW-1:0] a;
    logic [FullW-1:0] b;
    for (int unsigned k = 0; k < count; k++) begin
      a = rand128();
      b = rand128();
      if (cur_modulus != 0 && $urandom_range(99) < 80) begin
        a = a % cur_modulus;
        b = b % cur_modulus;
      end
      send_operands(a, b);
    end
  endtask

  task automatic test_reset_values();
    send_operands('0, '0);
    send_operands('1, '1);
    send_operands(128'd1, {64'h0, 64'hffff_ffff_ffff_ffff});
    send_operands({64'hffff_ffff_ffff_ffff, 64'h0}, 128'd7);
  endtask

  task automatic test_directed();
    logic [FullW-1:0] m;
    m = '1;
    load_modulus(m, neg_inverse_of(m));
    send_operands('0, m - 1);
    send_operands(m - 1, m - 1);
    send_operands(128'd1, 128'd1);
    send_operands('1, '1);
    m = 128'd3;
    load_modulus(m, neg_inverse_of(m));
    send_operands(128'd2, 128'd2);
    send_operands('1, 128'd5);
    m = rand128() | 128'd1 | (128'd1 << 127);
    load_modulus(m, neg_inverse_of(m));
    send_operands(m - 1, m - 1);
    send_operands('1, '1);
    send_operands(m, m);
    // inconsistent settings: zero and even modulus, wrong inverse
    load_modulus('0, '0);
    send_operands('0, '0);
    send_operands(128'd5, 128'd9);
    load_modulus(128'd10, rand128());
    send_operands(128'd3, 128'd4);
    send_operands('0, 128'd4);
    send_operands(rand128(), rand128());
  endtask

  task automatic test_random_phases();
    int unsigned tx_pct[4] = '{0, 78, 0, 7};
    int unsigned rx_pct[4] = '{0, 0, 78, 7};
    logic [FullW-1:0] m;
    for (int p = 0; p < 4; p++) begin
      m = rand128() | 128'd1;
      if (p == 3) m = {64'h0, rand64() | 64'd1};
      load_modulus(m, neg_inverse_of(m));
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      send_random(75);
    end
    load_modulus({rand64(), rand64() & ~64'd1}, rand128());
    send_random(12);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  // long receiver hold-off while items keep coming, enough to fill the chain
  task automatic test_backpressure();
    load_modulus('1, neg_inverse_of('1));
    @(negedge clk);
    hold_cycles = 200;
    send_random(120);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mm128_pkg::REG_MODULUS_LOW;
    cfg_data = '0;
    cur_modulus = 128'd1;
    cur_neg_inv = '1;
    mismatches = 0;
    items_sent = 0;
    products_seen = 0;
    failures_seen = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_drain();

    $display("Covered %0d items, %0d products (%0d reduction failures), over full and",
             items_sent, products_seen, failures_seen);
    $display("partial moduli, inconsistent settings, idle/stall mixes and a long hold-off.");
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
